>>> hw/rtl/half_block_ansi_pixel_encoder_assert.svh
// ============================================================================
// Assertion macros for the half-block pixel encoder
// Concurrent checks on clk, gated off during reset; empty in synthesis.
// ============================================================================
`ifndef HALF_BLOCK_ANSI_PIXEL_ENCODER_ASSERT_SVH
`define HALF_BLOCK_ANSI_PIXEL_ENCODER_ASSERT_SVH

`ifndef SYNTH

// implication that must hold at every clock edge out of reset
`define HBE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("hbe assertion failed");

// condition that must never be true out of reset
`define HBE_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("hbe forbidden condition");

`else

`define HBE_ASSERT(lbl, prop)
`define HBE_ASSERT_NEVER(lbl, cond)

`endif

`endif

>>> hw/rtl/hbe_pkg.sv
// ============================================================================
// hbe_pkg
// Shared types, byte constants and the escape-sequence token table.
// ============================================================================
package hbe_pkg;

    // default depth of the command queue between front and back
    localparam int CMD_DEPTH = 2;

    // byte constants of the text stream
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_FOUR  = 8'h34;
    localparam logic [7:0] CH_EIGHT = 8'h38;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] GLYPH_B0 = 8'hE2;
    localparam logic [7:0] GLYPH_B1 = 8'h96;
    localparam logic [7:0] GLYPH_B2 = 8'h80;

    // token positions inside one item's byte sequence
    localparam int TOK_W = 5;
    localparam logic [TOK_W-1:0] TOK_SEQ_START = 5'd0;
    localparam logic [TOK_W-1:0] TOK_GLYPH     = 5'd24;
    localparam logic [TOK_W-1:0] TOK_GLYPH_END = 5'd26;
    localparam logic [TOK_W-1:0] TOK_NEWLINE   = 5'd27;

    // number of printed color channels (alpha is never printed)
    localparam int NUM_CHAN = 6;
    localparam int CHAN_W   = 3;

    // decimal form of one channel, left aligned: d0 printed first
    typedef struct packed {
        logic [1:0] len;
        logic [3:0] d0;
        logic [3:0] d1;
        logic [3:0] d2;
    } dec_t;

    // one work word from front to back
    typedef struct packed {
        logic                      need_seq;
        logic                      newline;
        dec_t [NUM_CHAN-1:0]       dec;
    } cmd_t;

    // one token: a literal byte or the digits of a channel
    typedef struct packed {
        logic              is_dig;
        logic [CHAN_W-1:0] chan;
        logic [7:0]        lit;
    } tok_t;

    // queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic tok_t tok_lit(input logic [7:0] b);
        tok_t t;
        t.is_dig = 1'b0;
        t.chan   = '0;
        t.lit    = b;
        return t;
    endfunction

    function automatic tok_t tok_dig(input logic [CHAN_W-1:0] c);
        tok_t t;
        t.is_dig = 1'b1;
        t.chan   = c;
        t.lit    = '0;
        return t;
    endfunction

    // ESC[38;2;R;G;B;48;2;R;G;Bm then the glyph and the newline
    function automatic tok_t seq_tok(input logic [TOK_W-1:0] idx);
        tok_t t;
        case (idx)
            5'd0:    t = tok_lit(CH_ESC);
            5'd1:    t = tok_lit(CH_LBRK);
            5'd2:    t = tok_lit(CH_THREE);
            5'd3:    t = tok_lit(CH_EIGHT);
            5'd4:    t = tok_lit(CH_SEMI);
            5'd5:    t = tok_lit(CH_TWO);
            5'd6:    t = tok_lit(CH_SEMI);
            5'd7:    t = tok_dig(3'd0);
            5'd8:    t = tok_lit(CH_SEMI);
            5'd9:    t = tok_dig(3'd1);
            5'd10:   t = tok_lit(CH_SEMI);
            5'd11:   t = tok_dig(3'd2);
            5'd12:   t = tok_lit(CH_SEMI);
            5'd13:   t = tok_lit(CH_FOUR);
            5'd14:   t = tok_lit(CH_EIGHT);
            5'd15:   t = tok_lit(CH_SEMI);
            5'd16:   t = tok_lit(CH_TWO);
            5'd17:   t = tok_lit(CH_SEMI);
            5'd18:   t = tok_dig(3'd3);
            5'd19:   t = tok_lit(CH_SEMI);
            5'd20:   t = tok_dig(3'd4);
            5'd21:   t = tok_lit(CH_SEMI);
            5'd22:   t = tok_dig(3'd5);
            5'd23:   t = tok_lit(CH_M);
            5'd24:   t = tok_lit(GLYPH_B0);
            5'd25:   t = tok_lit(GLYPH_B1);
            5'd26:   t = tok_lit(GLYPH_B2);
            5'd27:   t = tok_lit(CH_NL);
            default: t = tok_lit(CH_NL);
        endcase
        return t;
    endfunction

    // shift-and-add-3 binary to BCD, then drop leading zeros
    function automatic dec_t to_dec(input logic [7:0] v);
        logic [19:0] sh;
        dec_t        d;
        sh = {12'd0, v};
        for (int i = 0; i < 8; i++) begin
            if (sh[11:8] > 4'd4)
                sh[11:8] = sh[11:8] + 4'd3;
            if (sh[15:12] > 4'd4)
                sh[15:12] = sh[15:12] + 4'd3;
            if (sh[19:16] > 4'd4)
                sh[19:16] = sh[19:16] + 4'd3;
            sh = {sh[18:0], 1'b0};
        end
        if (v >= 8'd100) begin
            d.len = 2'd3;
            d.d0  = sh[19:16];
            d.d1  = sh[15:12];
            d.d2  = sh[11:8];
        end
        else if (v >= 8'd10) begin
            d.len = 2'd2;
            d.d0  = sh[15:12];
            d.d1  = sh[11:8];
            d.d2  = 4'd0;
        end
        else begin
            d.len = 2'd1;
            d.d0  = sh[11:8];
            d.d1  = 4'd0;
            d.d2  = 4'd0;
        end
        return d;
    endfunction

endpackage

>>> hw/rtl/hbe_front.sv
// ============================================================================
// hbe_front
// Accepts pixel pairs, detects run breaks and converts colors to decimal.
// ============================================================================
module hbe_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [7:0]            upper_red,
    input  logic [7:0]            upper_green,
    input  logic [7:0]            upper_blue,
    input  logic [7:0]            upper_alpha,
    input  logic [7:0]            lower_red,
    input  logic [7:0]            lower_green,
    input  logic [7:0]            lower_blue,
    input  logic [7:0]            lower_alpha,
    input  logic                  row_end,
    input  logic                  frame_end,
    input  hbe_pkg::q_status_t    q_status,
    output logic                  cmd_push,
    output hbe_pkg::cmd_t         cmd
);

    logic [63:0] prev_pair_reg;
    logic        at_row_start_reg;
    logic [63:0] pair;

    assign full     = q_status.full;
    assign cmd_push = push && !q_status.full;

    // channel 0 in the low byte, alpha included for the run compare
    assign pair = {lower_alpha, lower_blue, lower_green, lower_red,
                   upper_alpha, upper_blue, upper_green, upper_red};

    // classify: color sequence needed, newline needed, decimal digits
    always_comb
    begin
        cmd.need_seq = at_row_start_reg || (pair != prev_pair_reg);
        cmd.newline  = row_end && !frame_end;
        cmd.dec[0]   = hbe_pkg::to_dec(upper_red);
        cmd.dec[1]   = hbe_pkg::to_dec(upper_green);
        cmd.dec[2]   = hbe_pkg::to_dec(upper_blue);
        cmd.dec[3]   = hbe_pkg::to_dec(lower_red);
        cmd.dec[4]   = hbe_pkg::to_dec(lower_green);
        cmd.dec[5]   = hbe_pkg::to_dec(lower_blue);
    end

    // run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pair_reg    <= '0;
            at_row_start_reg <= 1'b1;
        end
        else if (cmd_push)
        begin
            prev_pair_reg    <= pair;
            at_row_start_reg <= row_end || frame_end;
        end
    end

endmodule

>>> hw/rtl/hbe_cmd_fifo.sv
// ============================================================================
// hbe_cmd_fifo
// Short queue of work words between the front and the back.
// ============================================================================
module hbe_cmd_fifo #(
    parameter int DEPTH = hbe_pkg::CMD_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  hbe_pkg::cmd_t               wr_data,
    input  logic                        rd_en,
    output hbe_pkg::cmd_t               rd_data,
    output hbe_pkg::q_status_t          status,
    output logic [$clog2(DEPTH+1)-1:0]  level
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    hbe_pkg::cmd_t    mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_wr;
    logic             do_rd;

    assign status.full  = (cnt_reg == CNT_FULL);
    assign status.empty = (cnt_reg == '0);
    assign level        = cnt_reg;
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_data      = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

>>> hw/rtl/hbe_back.sv
// ============================================================================
// hbe_back
// Walks the token table for the head work word, one byte per cycle while popped.
// ============================================================================
module hbe_back (
    input  logic                clk,
    input  logic                rst_n,
    input  hbe_pkg::cmd_t       cmd,
    input  hbe_pkg::q_status_t  q_status,
    output logic                cmd_pop,
    output logic                empty,
    input  logic                pop,
    output logic [7:0]          out_byte,
    output logic                run_last
);

    logic [hbe_pkg::TOK_W-1:0] tok_reg;
    logic [1:0]                dig_reg;
    logic                      first_reg;
    logic                      out_valid_reg;
    logic [7:0]                out_byte_reg;
    logic                      run_last_reg;

    logic [hbe_pkg::TOK_W-1:0] tok_idx;
    logic [hbe_pkg::TOK_W-1:0] tok_end;
    hbe_pkg::tok_t             tok;
    hbe_pkg::dec_t             dd;
    logic [3:0]                digit;
    logic                      dig_last;
    logic                      item_last;
    logic [7:0]                byte_next;
    logic                      advance;

    // current token: item start point or saved position
    always_comb
    begin
        if (first_reg)
            tok_idx = cmd.need_seq ? hbe_pkg::TOK_SEQ_START : hbe_pkg::TOK_GLYPH;
        else
            tok_idx = tok_reg;
        tok_end   = cmd.newline ? hbe_pkg::TOK_NEWLINE : hbe_pkg::TOK_GLYPH_END;
        tok       = hbe_pkg::seq_tok(tok_idx);
        dd        = cmd.dec[tok.chan];
        case (dig_reg)
            2'd0:    digit = dd.d0;
            2'd1:    digit = dd.d1;
            default: digit = dd.d2;
        endcase
        dig_last  = (dig_reg == (dd.len - 2'd1));
        item_last = (tok_idx == tok_end);
        byte_next = tok.is_dig ? (hbe_pkg::CH_ZERO | {4'd0, digit}) : tok.lit;
    end

    assign advance  = !q_status.empty && (!out_valid_reg || pop);
    assign cmd_pop  = advance && item_last;
    assign empty    = !out_valid_reg;
    assign out_byte = out_byte_reg;
    assign run_last = run_last_reg;

    // sequencer position and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg       <= '0;
            dig_reg       <= '0;
            first_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            run_last_reg  <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
            out_byte_reg  <= byte_next;
            run_last_reg  <= item_last;
            if (item_last)
            begin
                first_reg <= 1'b1;
                dig_reg   <= '0;
            end
            else if (tok.is_dig && !dig_last)
            begin
                first_reg <= 1'b0;
                tok_reg   <= tok_idx;
                dig_reg   <= dig_reg + 2'd1;
            end
            else
            begin
                first_reg <= 1'b0;
                tok_reg   <= tok_idx + 1'b1;
                dig_reg   <= '0;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

>>> hw/rtl/half_block_ansi_pixel_encoder.sv
// An accepted pair is written into the command queue; the back then loads its bytes
// into a single output register, one byte per cycle while the consumer pops; a pair
// emits 3 or 4 bytes inside a run, up to 40 at a run start.
// The command queue lets the front take new pairs while the back emits bytes.
// Reset: rst_n (async, active low) empties the queue and output, clears the
// previous pair to zero and marks the next pair as a row start.
// ============================================================================
// half_block_ansi_pixel_encoder
// Turns pixel pairs into a truecolor terminal byte stream.
// ============================================================================
`include "half_block_ansi_pixel_encoder_assert.svh"

module half_block_ansi_pixel_encoder #(
    parameter int CMD_DEPTH = hbe_pkg::CMD_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] upper_red,
    input  logic [7:0] upper_green,
    input  logic [7:0] upper_blue,
    input  logic [7:0] upper_alpha,
    input  logic [7:0] lower_red,
    input  logic [7:0] lower_green,
    input  logic [7:0] lower_blue,
    input  logic [7:0] lower_alpha,
    input  logic       row_end,
    input  logic       frame_end,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       run_last
);

    localparam int LVL_W = $clog2(CMD_DEPTH + 1);

    hbe_pkg::cmd_t      front_cmd;
    hbe_pkg::cmd_t      head_cmd;
    hbe_pkg::q_status_t q_status;
    logic               cmd_push;
    logic               cmd_pop;
    logic [LVL_W-1:0]   q_level;

    hbe_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .upper_red   (upper_red),
        .upper_green (upper_green),
        .upper_blue  (upper_blue),
        .upper_alpha (upper_alpha),
        .lower_red   (lower_red),
        .lower_green (lower_green),
        .lower_blue  (lower_blue),
        .lower_alpha (lower_alpha),
        .row_end     (row_end),
        .frame_end   (frame_end),
        .q_status    (q_status),
        .cmd_push    (cmd_push),
        .cmd         (front_cmd)
    );

    hbe_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (front_cmd),
        .rd_en   (cmd_pop),
        .rd_data (head_cmd),
        .status  (q_status),
        .level   (q_level)
    );

    hbe_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (head_cmd),
        .q_status (q_status),
        .cmd_pop  (cmd_pop),
        .empty    (empty),
        .pop      (pop),
        .out_byte (out_byte),
        .run_last (run_last)
    );

    // queue never holds more words than its depth
    `HBE_ASSERT_NEVER(a_q_overfill, q_level > LVL_W'(CMD_DEPTH))
    // the back only retires a word that is in the queue
    `HBE_ASSERT_NEVER(a_pop_when_empty, cmd_pop && q_status.empty)
    // with no queued work and the output drained, nothing new appears
    `HBE_ASSERT(a_no_invented_byte, (q_status.empty && (empty || pop)) |=> empty)
    // a finished word leaves the queue exactly when its last byte is loaded
    `HBE_ASSERT(a_last_retires, cmd_pop |=> (!empty && run_last))

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the half-block pixel encoder: pushes pixel pairs,
// predicts the terminal byte stream and checks every popped word in order.
// ============================================================================
module tb_top;

    // one vertical pixel pair as pushed into the block
    typedef struct packed {
        logic [7:0] ur;
        logic [7:0] ug;
        logic [7:0] ub;
        logic [7:0] ua;
        logic [7:0] lr;
        logic [7:0] lg;
        logic [7:0] lb;
        logic [7:0] la;
        logic       row_end;
        logic       frame_end;
    } pixel_pair_t;

    // one expected word of the text stream
    typedef struct packed {
        logic [7:0] value;
        logic       is_last;
    } text_word_t;

    localparam int TAIL_CYCLES  = 20;
    localparam int RANDOM_ITEMS = 400;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       push        = 1'b0;
    logic       pop         = 1'b0;
    logic [7:0] upper_red   = '0;
    logic [7:0] upper_green = '0;
    logic [7:0] upper_blue  = '0;
    logic [7:0] upper_alpha = '0;
    logic [7:0] lower_red   = '0;
    logic [7:0] lower_green = '0;
    logic [7:0] lower_blue  = '0;
    logic [7:0] lower_alpha = '0;
    logic       row_end     = 1'b0;
    logic       frame_end   = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] out_byte;
    logic       run_last;

    // encoder state as the bench sees it
    logic [63:0] prev_pair_bits    = '0;
    logic        row_start_pending = 1'b1;
    text_word_t  expected_words[$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int hold_off_req   = 0;
    bit no_idle        = 1'b0;

    always #1 clk = ~clk;

    half_block_ansi_pixel_encoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .upper_red   (upper_red),
        .upper_green (upper_green),
        .upper_blue  (upper_blue),
        .upper_alpha (upper_alpha),
        .lower_red   (lower_red),
        .lower_green (lower_green),
        .lower_blue  (lower_blue),
        .lower_alpha (lower_alpha),
        .row_end     (row_end),
        .frame_end   (frame_end),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .run_last    (run_last)
    );

    // ------------------------------------------------------------------
    // Byte stream prediction
    // ------------------------------------------------------------------
    function automatic void add_word(input logic [7:0] b);
        text_word_t w;
        w.value   = b;
        w.is_last = 1'b0;
        expected_words.push_back(w);
    endfunction

    // decimal, no leading zeros
    function automatic void add_decimal(input logic [7:0] v);
        if (v >= 8'd100)
            add_word(hbe_pkg::CH_ZERO + 8'(v / 100));
        if (v >= 8'd10)
            add_word(hbe_pkg::CH_ZERO + 8'((v / 10) % 10));
        add_word(hbe_pkg::CH_ZERO + 8'(v % 10));
    endfunction

    function automatic void encode_pair(input pixel_pair_t p);
        logic [63:0] bits;
        text_word_t  w;
        bits = {p.la, p.lb, p.lg, p.lr, p.ua, p.ub, p.ug, p.ur};
        // color sequence at a row start or on any channel change
        if (row_start_pending || bits != prev_pair_bits)
        begin
            add_word(hbe_pkg::CH_ESC);
            add_word(hbe_pkg::CH_LBRK);
            add_word(hbe_pkg::CH_THREE);
            add_word(hbe_pkg::CH_EIGHT);
            add_word(hbe_pkg::CH_SEMI);
            add_word(hbe_pkg::CH_TWO);
            add_word(hbe_pkg::CH_SEMI);
            add_decimal(p.ur);
            add_word(hbe_pkg::CH_SEMI);
            add_decimal(p.ug);
            add_word(hbe_pkg::CH_SEMI);
            add_decimal(p.ub);
            add_word(hbe_pkg::CH_SEMI);
            add_word(hbe_pkg::CH_FOUR);
            add_word(hbe_pkg::CH_EIGHT);
            add_word(hbe_pkg::CH_SEMI);
            add_word(hbe_pkg::CH_TWO);
            add_word(hbe_pkg::CH_SEMI);
            add_decimal(p.lr);
            add_word(hbe_pkg::CH_SEMI);
            add_decimal(p.lg);
            add_word(hbe_pkg::CH_SEMI);
            add_decimal(p.lb);
            add_word(hbe_pkg::CH_M);
        end
        add_word(hbe_pkg::GLYPH_B0);
        add_word(hbe_pkg::GLYPH_B1);
        add_word(hbe_pkg::GLYPH_B2);
        // newline dropped on the last row of a frame
        if (p.row_end && !p.frame_end)
            add_word(hbe_pkg::CH_NL);
        w = expected_words.pop_back();
        w.is_last = 1'b1;
        expected_words.push_back(w);
        prev_pair_bits    = bits;
        row_start_pending = p.row_end || p.frame_end;
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------
    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // weighted toward the digit-count boundaries
    function automatic logic [7:0] pick_channel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 8'd0;
        else if (r < 25)
            return 8'd255;
        else if (r < 45)
            return 8'($urandom_range(0, 9));
        else if (r < 65)
            return 8'($urandom_range(10, 99));
        else
            return 8'($urandom_range(0, 255));
    endfunction

    function automatic pixel_pair_t make_pair(
        input logic [7:0] ur, input logic [7:0] ug, input logic [7:0] ub,
        input logic [7:0] ua, input logic [7:0] lr, input logic [7:0] lg,
        input logic [7:0] lb, input logic [7:0] la, input logic re,
        input logic fe);
        pixel_pair_t p;
        p.ur        = ur;
        p.ug        = ug;
        p.ub        = ub;
        p.ua        = ua;
        p.lr        = lr;
        p.lg        = lg;
        p.lb        = lb;
        p.la        = la;
        p.row_end   = re;
        p.frame_end = fe;
        return p;
    endfunction

    function automatic pixel_pair_t random_pair();
        return make_pair(pick_channel(), pick_channel(), pick_channel(), pick_channel(),
                         pick_channel(), pick_channel(), pick_channel(), pick_channel(),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    // change exactly one of the eight channels
    function automatic pixel_pair_t tweak_channel(input pixel_pair_t p);
        pixel_pair_t q;
        logic [7:0]  v;
        q = p;
        v = 8'($urandom_range(1, 255));
        case ($urandom_range(0, 7))
            0:       q.ur = p.ur ^ v;
            1:       q.ug = p.ug ^ v;
            2:       q.ub = p.ub ^ v;
            3:       q.ua = p.ua ^ v;
            4:       q.lr = p.lr ^ v;
            5:       q.lg = p.lg ^ v;
            6:       q.lb = p.lb ^ v;
            default: q.la = p.la ^ v;
        endcase
        return q;
    endfunction

    // ------------------------------------------------------------------
    // Sender: one pair per call, returns at the accepting edge
    // ------------------------------------------------------------------
    task automatic send_pair(input pixel_pair_t p);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push        <= 1'b1;
        upper_red   <= p.ur;
        upper_green <= p.ug;
        upper_blue  <= p.ub;
        upper_alpha <= p.ua;
        lower_red   <= p.lr;
        lower_green <= p.lg;
        lower_blue  <= p.lb;
        lower_alpha <= p.la;
        row_end     <= p.row_end;
        frame_end   <= p.frame_end;
        @(posedge clk);
        while (full)
            @(posedge clk);
        encode_pair(p);
        items_sent++;
    endtask

    // stop pushing until every expected word is out, then a short tail
    task automatic wait_drained();
        push <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------
    function automatic void note_mismatch(input string what, input logic [7:0] exp_v,
                                          input logic [7:0] act_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %0d on %s: expected %h, got %h", mismatch_count, what,
                     exp_v, act_v);
    endfunction

    function automatic void check_word();
        text_word_t w;
        if (expected_words.size() == 0)
        begin
            note_mismatch("unexpected word", 8'h00, out_byte);
            return;
        end
        w = expected_words.pop_front();
        if (out_byte !== w.value)
            note_mismatch("out_byte", w.value, out_byte);
        if (run_last !== w.is_last)
            note_mismatch("run_last", {7'd0, w.is_last}, {7'd0, run_last});
    endfunction

    initial
    begin : byte_sink
        int gap_left;
        int hold_left;
        gap_left  = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                check_word();
            // long hold-off requested by a test
            if (hold_off_req > 0)
            begin
                hold_left    = hold_off_req;
                hold_off_req = 0;
            end
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else if (gap_left > 0)
            begin
                pop <= 1'b0;
                gap_left--;
            end
            else
            begin
                pop <= 1'b1;
                gap_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // extremes, digit lengths, alpha-only change and row/frame end cases
    task automatic test_directed_cases();
        // row start forces the sequence even though the pair equals reset state
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(255, 255, 255, 255, 255, 255, 255, 255, 0, 0));
        send_pair(make_pair(255, 255, 255, 255, 255, 255, 255, 255, 0, 0));
        // alpha alone breaks the run
        send_pair(make_pair(255, 255, 255, 255, 255, 255, 255, 0, 0, 0));
        send_pair(make_pair(255, 255, 255, 255, 255, 255, 255, 0, 1, 0));
        // same colors after a row end: sequence again
        send_pair(make_pair(255, 255, 255, 255, 255, 255, 255, 0, 0, 0));
        send_pair(make_pair(9, 10, 99, 128, 100, 1, 200, 128, 0, 0));
        // frame end with row end: newline dropped
        send_pair(make_pair(9, 10, 99, 128, 100, 1, 200, 128, 1, 1));
        send_pair(make_pair(9, 10, 99, 128, 100, 1, 200, 128, 0, 0));
        // frame end without row end: no newline, next is a row start
        send_pair(make_pair(9, 10, 99, 128, 100, 1, 200, 128, 0, 1));
        send_pair(make_pair(9, 10, 99, 128, 100, 1, 200, 128, 0, 0));
        send_pair(make_pair(254, 127, 64, 1, 32, 16, 8, 2, 0, 0));
        send_pair(make_pair(254, 127, 64, 1, 32, 16, 8, 2, 1, 0));
        send_pair(make_pair(0, 0, 0, 255, 0, 0, 0, 255, 1, 0));
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(0, 0, 1, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(0, 0, 1, 0, 0, 0, 0, 0, 1, 1));
        wait_drained();
    endtask

    // receiver stalls for a long time while the sender keeps pushing
    task automatic test_backpressure();
        hold_off_req = 400;
        no_idle      = 1'b1;
        repeat (16) send_pair(random_pair());
        no_idle = 1'b0;
        wait_drained();
    endtask

    // mostly well-formed frames with runs, some raw noise
    task automatic test_random_frames();
        pixel_pair_t p;
        int          target;
        int          width;
        int          rows;
        int          r;
        p      = random_pair();
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 8)
            begin
                width = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12)
                                                    : $urandom_range(1, 6);
                rows  = $urandom_range(1, 3);
                for (int row = 0; row < rows; row++)
                begin
                    for (int col = 0; col < width; col++)
                    begin
                        r = $urandom_range(0, 99);
                        if (r < 50)
                            p = p;
                        else if (r < 70)
                            p = tweak_channel(p);
                        else
                            p = random_pair();
                        p.row_end   = (col == width - 1);
                        p.frame_end = (col == width - 1) && (row == rows - 1);
                        send_pair(p);
                    end
                end
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                begin
                    p = ($urandom_range(0, 1) == 0) ? random_pair() : tweak_channel(p);
                    p.row_end   = 1'($urandom_range(0, 1));
                    p.frame_end = 1'($urandom_range(0, 1));
                    send_pair(p);
                end
            end
        end
        no_idle = 1'b0;
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_backpressure();
        test_random_frames();
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // run limit
    initial
    begin
        #10000000;
        $display("status: fail");
        $finish;
    end

endmodule
